@@ design/gksp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package gksp_pkg;

	localparam int DEF_MAX_BINS = 1024;
	localparam int DEF_MAX_HITS = 63;

	localparam int GATE_W   = 32;
	localparam int MULT_W   = 4;
	localparam int FREQ_W   = 32;
	localparam int POW_W    = 24;
	localparam int THR_W    = 27;
	localparam int TOTAL_W  = 11;
	localparam int SUM_W    = 34;
	localparam int SQSUM_W  = 58;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_NOISE_GATE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIGMA_MULT = 1'd1;

	localparam logic [GATE_W-1:0] NOISE_GATE_RST = 32'd3277;
	localparam logic [MULT_W-1:0] SIGMA_MULT_RST = 4'd5;

	localparam logic KIND_HIT     = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic [FREQ_W-1:0] bin_frequency;
		logic [POW_W-1:0]  bin_power;
		logic              last_bin;
	} bin_req_t;

	typedef struct packed {
		logic              item_kind;
		logic [FREQ_W-1:0] hit_frequency;
		logic [POW_W-1:0]  hit_power;
		logic [31:0]       hit_period;
		logic [THR_W-1:0]  threshold;
		logic              threshold_valid;
		logic [TOTAL_W-1:0] hit_total;
		logic              hits_dropped;
		logic              last_result;
	} hit_req_t;

	// request to / answer from the shared divider
	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [31:0] divisor;
	} div_cmd_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
	} div_rsp_t;

endpackage
`default_nettype wire

@@ design/gksp_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module gksp_div (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire gksp_pkg::div_cmd_t   cmd,
	output gksp_pkg::div_rsp_t        rsp
);
	import gksp_pkg::*;

	logic        busy_q;
	logic [6:0]  cnt_q;
	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dvs_q;
	logic [32:0] trial;
	logic [33:0] diff;

	assign trial = {rem_q[31:0], quo_q[63]};
	assign diff  = {1'b0, trial} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			cnt_q  <= 7'd0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 7'd1;
			if (cnt_q == 7'd63)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			quo_q <= cmd.dividend;
			rem_q <= '0;
			dvs_q <= cmd.divisor;
		end else if (busy_q) begin
			if (!diff[33]) begin
				rem_q <= diff[32:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	// the last step's quotient is presented while it is being computed
	assign rsp.done     = busy_q && (cnt_q == 7'd63);
	assign rsp.quotient = !diff[33] ? {quo_q[62:0], 1'b1} : {quo_q[62:0], 1'b0};
endmodule
`default_nettype wire

@@ design/gated_k_sigma_peak_detector.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Load: a bin whose frequency is above the gate, while the store has room, is written
// to the store and then added into both sums; other bins are not stored. On the last bin:
// two divisions, a square root (alignment, then iteration), then a scan of the stored
// bins with a period division per reported hit; the input stalls until the summary is queued.
// Reset (arst_n low) clears control state, sums and count and restores the
// register defaults; the bin store keeps its contents and needs no clearing.
module gated_k_sigma_peak_detector #(
	parameter int MAX_BINS = gksp_pkg::DEF_MAX_BINS,
	parameter int MAX_HITS = gksp_pkg::DEF_MAX_HITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output      logic                          in_stall,
	input  wire gksp_pkg::bin_req_t            in_data,
	output      logic                          out_valid,
	input  wire logic                          out_stall,
	output gksp_pkg::hit_req_t                 out_data,
	input  wire logic                          cfg_we,
	input  wire logic [gksp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [gksp_pkg::CFG_DAT_W-1:0] cfg_data
);
	import gksp_pkg::*;

	localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int CW = $clog2(MAX_BINS + 1);
	localparam int HW = $clog2(MAX_HITS + 1);

	typedef enum logic [14:0] {
		S_IDLE  = 15'b000000000000001,
		S_ACC   = 15'b000000000000010,
		S_DIV1  = 15'b000000000000100,
		S_DIV2  = 15'b000000000001000,
		S_MSQ   = 15'b000000000010000,
		S_VAR   = 15'b000000000100000,
		S_SQRT  = 15'b000000001000000,
		S_THR   = 15'b000000010000000,
		S_RD    = 15'b000000100000000,
		S_CMP   = 15'b000001000000000,
		S_PER   = 15'b000010000000000,
		S_OUT   = 15'b000100000000000,
		S_SUM   = 15'b001000000000000,
		S_WAIT1 = 15'b010000000000000,
		S_WAIT2 = 15'b100000000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [GATE_W-1:0] gate_q;
	logic [MULT_W-1:0] mult_q, mult_s_q;

	// bin store
	logic [FREQ_W-1:0] freq_mem [MAX_BINS];
	logic [POW_W-1:0]  pow_mem  [MAX_BINS];
	logic [FREQ_W-1:0] rd_freq_q;
	logic [POW_W-1:0]  rd_pow_q;

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      scan_q;
	logic [SUM_W-1:0]   sum_q;
	logic [SQSUM_W-1:0] sqsum_q;
	logic [POW_W-1:0]   pow_q;
	logic               last_q;

	logic [31:0]        mean_q;
	logic [63:0]        msq_q;
	logic [63:0]        var_q;
	logic [63:0]        root_q;
	logic [63:0]        bit_q;
	logic [THR_W-1:0]   thr_q;
	logic               thr_valid_q;
	logic [TOTAL_W-1:0] total_q;
	logic [HW-1:0]      sent_q;
	logic [31:0]        per_q;
	// set when the current scanned bin produced a period to report
	logic               hit_flag_q;

	hit_req_t out_q;
	logic     out_valid_q;

	div_cmd_t div_cmd;
	div_rsp_t div_rsp;

	gksp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.rsp    (div_rsp)
	);

	logic accept;
	logic gated_in;
	logic out_free;
	logic out_load;
	logic [64:0] sq_trial;
	logic [37:0] thr_wide;
	logic [63:0] mean_sq;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign gated_in  = (in_data.bin_frequency > gate_q) && (count_q < CW'(MAX_BINS));
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// the output register can take a new request this cycle
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = out_free && ((state_q == S_SUM) ||
		(state_q == S_OUT && THR_W'(rd_pow_q) > thr_q && hit_flag_q));

	// one root step: try (res + bit) against the remaining value
	assign sq_trial = {1'b0, root_q} + {1'b0, bit_q};
	assign mean_sq  = 64'(mean_q) * 64'(mean_q);
	assign thr_wide = 38'(mean_q) + 38'(mult_s_q) * 38'(root_q[31:0]);

	always_comb begin
		div_cmd.start    = 1'b0;
		div_cmd.dividend = {{(64-SUM_W){1'b0}}, sum_q};
		div_cmd.divisor  = 32'(count_q);
		case (state_q)
			S_WAIT1: div_cmd.start = 1'b1;
			S_DIV1: begin
				if (div_rsp.done) begin
					div_cmd.start    = 1'b1;
					div_cmd.dividend = {{(64-SQSUM_W){1'b0}}, sqsum_q};
				end
			end
			S_CMP: begin
				if (rd_pow_q > POW_W'(0) && 27'(rd_pow_q) > thr_q && sent_q < HW'(MAX_HITS)) begin
					div_cmd.start    = 1'b1;
					div_cmd.dividend = 64'h1_0000_0000;
					div_cmd.divisor  = rd_freq_q;
				end
				if (!(27'(rd_pow_q) > thr_q)) div_cmd.start = 1'b0;
			end
			default: ;
		endcase
	end

	// store write and read
	always_ff @(posedge clk) begin
		if (accept && gated_in) begin
			freq_mem[count_q[AW-1:0]] <= in_data.bin_frequency;
			pow_mem[count_q[AW-1:0]]  <= in_data.bin_power;
		end
		rd_freq_q <= freq_mem[scan_q[AW-1:0]];
		rd_pow_q  <= pow_mem[scan_q[AW-1:0]];
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q <= NOISE_GATE_RST;
			mult_q <= SIGMA_MULT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NOISE_GATE: gate_q <= cfg_data;
				REG_SIGMA_MULT: mult_q <= cfg_data[MULT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			sum_q       <= '0;
			sqsum_q     <= '0;
			out_valid_q <= 1'b0;
			scan_q      <= '0;
			total_q     <= '0;
			sent_q      <= '0;
			thr_valid_q <= 1'b0;
			last_q      <= 1'b0;
			hit_flag_q  <= 1'b0;
		end else begin
			// load a new request, or hold the current one while stalled
			out_valid_q <= out_load || (out_valid_q && out_stall);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q   <= in_data.last_bin;
						mult_s_q <= mult_q;
						pow_q    <= in_data.bin_power;
						if (gated_in) begin
							count_q <= count_q + CW'(1);
							state_q <= S_ACC;
						end else if (in_data.last_bin) begin
							state_q <= S_WAIT2;
						end
					end
				end
				S_ACC: begin
					// add the bin into both sums
					sum_q   <= sum_q + SUM_W'(pow_q);
					sqsum_q <= sqsum_q + SQSUM_W'(48'(pow_q) * 48'(pow_q));
					state_q <= last_q ? S_WAIT2 : S_IDLE;
				end
				S_WAIT2: begin
					if (count_q == '0) begin
						thr_q       <= '0;
						thr_valid_q <= 1'b0;
						total_q     <= '0;
						state_q     <= S_SUM;
					end else begin
						state_q <= S_WAIT1;
					end
				end
				S_WAIT1: state_q <= S_DIV1;
				S_DIV1: begin
					if (div_rsp.done) begin
						mean_q  <= div_rsp.quotient[31:0];
						state_q <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (div_rsp.done) begin
						msq_q   <= div_rsp.quotient;
						state_q <= S_MSQ;
					end
				end
				S_MSQ: begin
					var_q   <= (msq_q > mean_sq) ? msq_q - mean_sq : 64'd0;
					root_q  <= '0;
					bit_q   <= 64'h4000_0000_0000_0000;
					state_q <= S_VAR;
				end
				S_VAR: begin
					// drop the start bit below the value
					if (bit_q > var_q) bit_q <= bit_q >> 2;
					else state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (bit_q == '0) begin
						state_q <= S_THR;
					end else begin
						if (var_q >= sq_trial[63:0]) begin
							var_q  <= var_q - sq_trial[63:0];
							root_q <= (root_q >> 1) + bit_q;
						end else begin
							root_q <= root_q >> 1;
						end
						bit_q <= bit_q >> 2;
					end
				end
				S_THR: begin
					thr_q       <= (thr_wide > 38'h7FF_FFFF) ? 27'h7FF_FFFF : thr_wide[THR_W-1:0];
					thr_valid_q <= 1'b1;
					total_q     <= '0;
					sent_q      <= '0;
					scan_q      <= '0;
					state_q     <= S_RD;
				end
				S_RD: state_q <= S_CMP;
				S_CMP: begin
					if (27'(rd_pow_q) > thr_q) begin
						total_q <= total_q + TOTAL_W'(1);
						if (sent_q < HW'(MAX_HITS)) state_q <= S_PER;
						else state_q <= S_OUT;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_PER: begin
					if (div_rsp.done) begin
						per_q <= (div_rsp.quotient[63:32] != '0) ? 32'hFFFF_FFFF
						         : div_rsp.quotient[31:0];
						state_q    <= S_OUT;
						sent_q     <= sent_q + HW'(1);
						hit_flag_q <= 1'b1;
					end
				end
				S_OUT: begin
					// hold the hit until the output register is free
					if (out_free) begin
						if (out_load) begin
							out_q.item_kind       <= KIND_HIT;
							out_q.hit_frequency   <= rd_freq_q;
							out_q.hit_power       <= rd_pow_q;
							out_q.hit_period      <= per_q;
							out_q.threshold       <= thr_q;
							out_q.threshold_valid <= 1'b1;
							out_q.hit_total       <= '0;
							out_q.hits_dropped    <= 1'b0;
							out_q.last_result     <= 1'b0;
						end
						hit_flag_q <= 1'b0;
						if (scan_q + CW'(1) == count_q) state_q <= S_SUM;
						else state_q <= S_RD;
						scan_q <= scan_q + CW'(1);
					end
				end
				S_SUM: begin
					if (out_free) begin
						out_q.item_kind       <= KIND_SUMMARY;
						out_q.hit_frequency   <= '0;
						out_q.hit_power       <= '0;
						out_q.hit_period      <= '0;
						out_q.threshold       <= thr_q;
						out_q.threshold_valid <= thr_valid_q;
						out_q.hit_total       <= total_q;
						out_q.hits_dropped    <= (total_q > TOTAL_W'(MAX_HITS));
						out_q.last_result     <= 1'b1;
						count_q <= '0;
						sum_q   <= '0;
						sqsum_q <= '0;
						scan_q  <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
